[rtl/srpp_pkg.sv]
// Shared types and constants for the shared-rate packet pacer.
`timescale 1ns / 1ps
package srpp_pkg;

  localparam int unsigned QueueDepth = 128;
  localparam int unsigned QAddrW     = $clog2(QueueDepth);
  localparam int unsigned QCountW    = QAddrW + 1;
  localparam int unsigned MaxPeers   = 64;
  localparam int unsigned PeerW      = $clog2(MaxPeers);
  localparam int unsigned Prod1W     = 46;  // 16-bit length times 1e9
  localparam int unsigned DivW       = 53;  // times a 7-bit active count
  localparam int unsigned DivCntW    = $clog2(DivW + 1);

  localparam logic [29:0] NsPerSec = 30'd1000000000;
  localparam logic [9:0]  NsPerUs  = 10'd1000;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEER = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED = 3'd0,
    STS_DROPPED  = 3'd1,
    STS_SENT     = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_HELD     = 3'd4,
    STS_PEER     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_RATE   = 2'd0,
    REG_SYNC       = 2'd1,
    REG_Q_LIMIT    = 2'd2,
    REG_WD_SLACK   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SYNC,
    ST_CHECK,
    ST_MUL2,
    ST_DIV,
    ST_ADJ,
    ST_SEND,
    ST_DONE
  } state_e;

endpackage

[rtl/shared_rate_packet_pacer.sv]
// Top level: descriptor FIFO pacer with shared-rate gap computation.
// Enqueue, peer report and empty dequeue go read to done; a held dequeue runs check;
// an unpaced send runs send; a paced send runs check, multiply, the 53-step divider,
// adjust and send; a recount adds sync. One word in flight: the next is taken the
// cycle after the result is registered, and a stalled result holds the input off.
// Reset clears all control state and peer valid bits; FIFO memory is not cleared.
`timescale 1ns / 1ps
module shared_rate_packet_pacer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] packet_handle_i,
  input  logic [15:0] packet_length_i,
  input  logic [63:0] now_ns_i,
  input  logic [5:0]  peer_index_i,
  input  logic [63:0] peer_sent_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] out_handle_o,
  output logic [15:0] out_length_o,
  output logic        wake_request_o,
  output logic [63:0] wake_time_ns_o,
  output logic [6:0]  share_count_o,
  output logic [63:0] sent_total_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import srpp_pkg::*;

  // configuration
  logic [31:0] max_rate_q, sync_us_q;
  logic [6:0]  limit_q;
  logic [41:0] sync_ns_q;

  // control state
  state_e              state_q, state_d;
  logic [QAddrW-1:0]   head_q, head_d;
  logic [QCountW-1:0]  count_q, count_d;
  logic [63:0]         next_send_q, next_send_d;
  logic [63:0]         last_wake_q, last_wake_d;
  logic [63:0]         last_sync_q, last_sync_d;
  logic [6:0]          active_q, active_d;
  logic [MaxPeers-1:0] changed_q, changed_d;
  logic [MaxPeers-1:0] pvalid_q, pvalid_d;
  logic [63:0]         sent_q, sent_d;
  logic [2:0]          sync_step_q, sync_step_d;
  logic                out_valid_q;

  // item and datapath
  logic [1:0]        kind_q;
  logic [15:0]       handle_q, length_q;
  logic [63:0]       now_q, pcount_q;
  logic [PeerW-1:0]  peer_q;
  logic [Prod1W-1:0] prod1_q, prod1_d;
  logic [DivW-1:0]   prod2_q, prod2_d;
  logic [63:0]       gap_q, gap_d;

  // result staging
  logic [2:0]  res_status_q, res_status_d;
  logic [15:0] res_handle_q, res_handle_d, res_length_q, res_length_d;
  logic        res_wake_q, res_wake_d;
  logic [63:0] res_wtime_q, res_wtime_d;
  logic [2:0]  o_status_q;
  logic [15:0] o_handle_q, o_length_q;
  logic        o_wake_q;
  logic [63:0] o_wtime_q, o_sent_q;
  logic [6:0]  o_active_q;

  // memories
  logic [31:0] fifo_mem [QueueDepth];
  logic [63:0] peer_mem [MaxPeers];
  logic [31:0] fifo_rd_q;
  logic [63:0] peer_rd_q;
  logic        fifo_we, peer_we;
  logic [QAddrW-1:0] fifo_wa;

  logic        accept, out_free, div_start, div_done;
  logic [DivW-1:0] div_quo;
  logic [63:0] snap, late, half;
  logic [7:0]  chunk;
  logic [3:0]  ones;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= '0;
      sync_us_q  <= 32'd100000;
      limit_q    <= 7'd100;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MAX_RATE: max_rate_q <= cfg_data_i;
        REG_SYNC:     sync_us_q  <= cfg_data_i;
        REG_Q_LIMIT:  limit_q    <= cfg_data_i[6:0];
        // slack only matters to the external wake timer
        REG_WD_SLACK: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    sync_ns_q <= 42'(sync_us_q * NsPerUs);
  end

  // memory ports
  assign fifo_wa = head_q + count_q[QAddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[fifo_wa] <= {handle_q, length_q};
    if (accept)  fifo_rd_q <= fifo_mem[head_q];
    if (peer_we) peer_mem[peer_q] <= pcount_q;
    if (accept)  peer_rd_q <= peer_mem[peer_index_i];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      handle_q <= packet_handle_i;
      length_q <= packet_length_i;
      now_q    <= now_ns_i;
      peer_q   <= peer_index_i;
      pcount_q <= peer_sent_count_i;
    end
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    gap_q   <= gap_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_length_q <= res_length_d;
    res_wake_q   <= res_wake_d;
    res_wtime_q  <= res_wtime_d;
  end

  srpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod2_q),
    .divisor_i  (max_rate_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign snap = pvalid_q[peer_q] ? peer_rd_q : '0;
  assign late = now_q - next_send_q;
  assign half = gap_q >> 1;

  always_comb begin
    chunk = changed_q[sync_step_q*8 +: 8];
    ones  = '0;
    for (int i = 0; i < 8; i++) ones = ones + 4'(chunk[i]);
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    next_send_d  = next_send_q;
    last_wake_d  = last_wake_q;
    last_sync_d  = last_sync_q;
    active_d     = active_q;
    changed_d    = changed_q;
    pvalid_d     = pvalid_q;
    sent_d       = sent_q;
    sync_step_d  = sync_step_q;
    prod1_d      = prod1_q;
    prod2_d      = prod2_q;
    gap_d        = gap_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_length_d = res_length_q;
    res_wake_d   = res_wake_q;
    res_wtime_d  = res_wtime_q;
    fifo_we      = 1'b0;
    peer_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d      = ST_READ;
          res_status_d = STS_EMPTY;
          res_handle_d = '0;
          res_length_d = '0;
          res_wake_d   = 1'b0;
          res_wtime_d  = '0;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
        case (kind_e'(kind_q))
          KIND_ENQ: begin
            if (count_q > {1'b0, limit_q} || count_q >= QCountW'(QueueDepth)) begin
              res_status_d = STS_DROPPED;
            end else begin
              fifo_we      = 1'b1;
              count_d      = count_q + 1'b1;
              res_status_d = STS_ACCEPTED;
            end
          end
          KIND_DEQ: begin
            if (count_q == '0) begin
              res_status_d = STS_EMPTY;
            end else if (max_rate_q == '0) begin
              state_d = ST_SEND;
              gap_d   = '0;
            end else if (now_q - last_sync_q >= {22'd0, sync_ns_q}) begin
              state_d     = ST_SYNC;
              sync_step_d = '0;
              active_d    = 7'd1;
            end else begin
              state_d = ST_CHECK;
            end
          end
          KIND_PEER: begin
            if (snap != pcount_q) changed_d[peer_q] = 1'b1;
            peer_we          = 1'b1;
            pvalid_d[peer_q] = 1'b1;
            res_status_d     = STS_PEER;
          end
          default: res_status_d = STS_EMPTY;
        endcase
      end
      ST_SYNC: begin
        // count marks a byte per cycle
        active_d    = active_q + 7'(ones);
        sync_step_d = sync_step_q + 1'b1;
        if (sync_step_q == 3'd7) begin
          changed_d   = '0;
          last_sync_d = now_q;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (next_send_q <= now_q) begin
          prod1_d = Prod1W'(fifo_rd_q[15:0] * NsPerSec);
          state_d = ST_MUL2;
        end else begin
          res_status_d = STS_HELD;
          if (next_send_q != last_wake_q) begin
            res_wake_d  = 1'b1;
            res_wtime_d = next_send_q;
            last_wake_d = next_send_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_MUL2: begin
        prod2_d = DivW'(prod1_q * active_q);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // start pulses on entry; done rises once the divider has shifted in all quotient bits
        if (div_done) begin
          gap_d   = {{(64-DivW){1'b0}}, div_quo};
          state_d = ST_ADJ;
        end
      end
      ST_ADJ: begin
        if (next_send_q != '0) gap_d = gap_q - ((half < late) ? half : late);
        state_d = ST_SEND;
      end
      ST_SEND: begin
        res_status_d = STS_SENT;
        res_handle_d = fifo_rd_q[31:16];
        res_length_d = fifo_rd_q[15:0];
        head_d       = head_q + 1'b1;
        count_d      = count_q - 1'b1;
        sent_d       = sent_q + 1'b1;
        if (max_rate_q != '0) next_send_d = now_q + gap_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // kick the divider on entry to the divide state
  logic div_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_go_q <= 1'b0;
    else         div_go_q <= (state_q == ST_MUL2);
  end
  assign div_start = div_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      next_send_q <= '0;
      last_wake_q <= '0;
      last_sync_q <= '0;
      active_q    <= '0;
      changed_q   <= '0;
      pvalid_q    <= '0;
      sent_q      <= '0;
      sync_step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      next_send_q <= next_send_d;
      last_wake_q <= last_wake_d;
      last_sync_q <= last_sync_d;
      active_q    <= active_d;
      changed_q   <= changed_d;
      pvalid_q    <= pvalid_d;
      sent_q      <= sent_d;
      sync_step_q <= sync_step_d;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      o_status_q <= res_status_q;
      o_handle_q <= res_handle_q;
      o_length_q <= res_length_q;
      o_wake_q   <= res_wake_q;
      o_wtime_q  <= res_wtime_q;
      o_active_q <= active_q;
      o_sent_q   <= sent_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign out_handle_o    = o_handle_q;
  assign out_length_o    = o_length_q;
  assign wake_request_o  = o_wake_q;
  assign wake_time_ns_o  = o_wtime_q;
  assign share_count_o   = o_active_q;
  assign sent_total_o    = o_sent_q;
endmodule

[rtl/srpp_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module srpp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [srpp_pkg::DivW-1:0]    dividend_i,
  input  logic [31:0]                  divisor_i,
  output logic                         done_o,
  output logic [srpp_pkg::DivW-1:0]    quotient_o
);
  import srpp_pkg::*;

  logic [DivW-1:0]    quo_q;
  logic [32:0]        rem_q;
  logic [31:0]        dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [32:0]        rem_sh;
  logic               ge;

  assign rem_sh = {rem_q[31:0], quo_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
